[src/tpq_pkg.sv]
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared types and constants of the task priority queue: item structs,
// action and status codes, cell control and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package tpq_pkg;

  // default geometry
  localparam int unsigned DepthDef      = 32;
  localparam int unsigned TaskIdBitsDef = 8;

  // fixed field widths of the item formats
  localparam int unsigned ActionW = 3;
  localparam int unsigned FieldW  = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OccW    = 6;

  typedef enum logic [ActionW-1:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_INS_PRIO   = 3'd2,
    ACT_INS_AFTER  = 3'd3,
    ACT_REMOVE     = 3'd4,
    ACT_POP_FRONT  = 3'd5
  } tpq_action_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } tpq_status_e;

  // how the cell row moves on the update cycle
  typedef enum logic [2:0] {
    MODE_NONE,
    MODE_BACK,
    MODE_FRONT,
    MODE_PRIO,
    MODE_AFTER,
    MODE_REMOVE,
    MODE_POP
  } tpq_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } tpq_state_e;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic      capture;
    logic      by_id;
    tpq_mode_e mode;
  } tpq_ctrl_t;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [FieldW-1:0]  task_id;
    logic [FieldW-1:0]  priority_req;
    logic [FieldW-1:0]  ref_task;
  } tpq_in_t;

  typedef struct packed {
    logic [FieldW-1:0]  out_task;
    logic               out_valid;
    logic [StatusW-1:0] status;
    logic [OccW-1:0]    occupancy;
  } tpq_out_t;

endpackage

`default_nettype wire

[src/tpq_cell.sv]
// ----------------------------------------------------------------------------
// tpq_cell
// One queue slot: holds a task id and priority, compares them against the
// request, and takes its neighbor's entry when the row shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module tpq_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 6,
  parameter int unsigned TW    = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire tpq_pkg::tpq_ctrl_t   ctrl_i,
  input  wire logic [CNT_W-1:0]     cnt_i,
  input  wire logic [TW-1:0]        new_task_i,
  input  wire logic [7:0]           new_prio_i,
  input  wire logic [TW-1:0]        key_i,
  input  wire logic [TW-1:0]        left_task_i,
  input  wire logic [7:0]           left_prio_i,
  input  wire logic                 left_ge_i,
  input  wire logic                 left_seen_i,
  input  wire logic [TW-1:0]        right_task_i,
  input  wire logic [7:0]           right_prio_i,
  output logic [TW-1:0]             task_o,
  output logic [7:0]                prio_o,
  output logic                      ge_o,
  output logic                      seen_o
);
  import tpq_pkg::*;

  localparam bit IsHead = (IDX == 0);

  logic [TW-1:0] task_q, task_d;
  logic [7:0]    prio_q, prio_d;
  logic          hit_q;
  logic          valid;
  logic          cmp;
  logic          seen_self;
  logic          ge;

  // slot holds a live entry
  assign valid = (CNT_W'(IDX) < cnt_i);

  // local match: id equality, or the priority stop rule
  always_comb begin
    if (ctrl_i.by_id) begin
      cmp = (task_q == key_i);
    end else if (IsHead) begin
      cmp = (new_prio_i <= prio_q);
    end else begin
      cmp = (prio_q > new_prio_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (ctrl_i.capture) begin
      hit_q <= valid & cmp;
    end
  end

  // first-match chain through the row
  assign seen_self = left_seen_i | hit_q;
  assign seen_o    = seen_self;

  // slot sits at or beyond the insert / remove position
  always_comb begin
    case (ctrl_i.mode)
      MODE_BACK:   ge = ~valid;
      MODE_FRONT:  ge = 1'b1;
      MODE_PRIO:   ge = seen_self | ~valid;
      MODE_AFTER:  ge = left_seen_i;
      MODE_REMOVE: ge = seen_self;
      MODE_POP:    ge = 1'b1;
      default:     ge = 1'b0;
    endcase
  end
  assign ge_o = ge;

  // shift right on insert, left on remove and pop
  always_comb begin
    task_d = task_q;
    prio_d = prio_q;
    case (ctrl_i.mode) inside
      MODE_BACK, MODE_FRONT, MODE_PRIO, MODE_AFTER: begin
        if (left_ge_i) begin
          task_d = left_task_i;
          prio_d = left_prio_i;
        end else if (ge) begin
          task_d = new_task_i;
          prio_d = new_prio_i;
        end
      end
      MODE_REMOVE, MODE_POP: begin
        if (ge) begin
          task_d = right_task_i;
          prio_d = right_prio_i;
        end
      end
      default: begin
        task_d = task_q;
        prio_d = prio_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    task_q <= task_d;
    prio_q <= prio_d;
  end

  assign task_o = task_q;
  assign prio_o = prio_q;

endmodule

`default_nettype wire

[src/task_priority_queue_unit.sv]
// ----------------------------------------------------------------------------
// task_priority_queue_unit
// Ordered task queue built as a row of shifting cells with a small sequencer.
// ----------------------------------------------------------------------------
// Usage: requests enter on in_valid_i / in_ready_o with in_data_i (action,
// task id, priority, reference task). Each request yields exactly one item
// on out_valid_o / out_ready_i carrying the popped task, a status and the
// occupancy after the operation.
// Sequence: an accepted item is held in the request register; the compare
// state registers the per-cell compares, and the update state resolves the
// first match along the cell chain, shifts the row and registers the result.
// Flow: a new request is taken only in the idle state, so each item goes
// through the compare and shift passes over the cell row before the next.
// Reset: the queue is empty and no result is pending; entry contents are
// not cleared and need no sweep.
// Stall: a finished result waits in the output register; the next request
// is still accepted and processed up to its update, which holds until the
// output register is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module task_priority_queue_unit #(
  parameter int unsigned DEPTH        = tpq_pkg::DepthDef,
  parameter int unsigned TASK_ID_BITS = tpq_pkg::TaskIdBitsDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire tpq_pkg::tpq_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output tpq_pkg::tpq_out_t     out_data_o
);
  import tpq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned TW   = TASK_ID_BITS;

  tpq_state_e     state_q, state_d;
  tpq_in_t        req_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  tpq_out_t       out_q, out_d;
  logic           out_valid_q;
  logic           commit;
  tpq_ctrl_t      ctrl;
  tpq_mode_e      mode;
  tpq_action_e    act;
  logic           full, empty, found;
  logic [TW-1:0]  new_task, key;

  logic [TW-1:0]  task_w [DEPTH+1];
  logic [7:0]     prio_w [DEPTH+1];
  logic           ge_w   [DEPTH+1];
  logic           seen_w [DEPTH+1];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_CMP;
      ST_CMP:  state_d = ST_UPD;
      ST_UPD:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    commit     = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_CMP:  ;
      ST_UPD:  commit = ~out_valid_q | out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // request register
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_data_i;
    end
  end

  assign act      = tpq_action_e'(req_q.action);
  assign new_task = TW'(req_q.task_id);
  assign key      = (act == ACT_INS_AFTER) ? TW'(req_q.ref_task) : TW'(req_q.task_id);
  assign full     = (cnt_q == CntW'(DEPTH));
  assign empty    = (cnt_q == '0);
  assign found    = seen_w[DEPTH];

  // operation decode on the update cycle
  always_comb begin
    mode          = MODE_NONE;
    out_d         = '0;
    out_d.status  = STAT_OK;
    cnt_d         = cnt_q;
    unique case (act) inside
      ACT_PUSH_BACK, ACT_PUSH_FRONT, ACT_INS_PRIO: begin
        if (full) begin
          out_d.status = STAT_FULL;
        end else begin
          mode  = (act == ACT_PUSH_BACK)  ? MODE_BACK :
                  (act == ACT_PUSH_FRONT) ? MODE_FRONT : MODE_PRIO;
          cnt_d = cnt_q + 1'b1;
        end
      end
      ACT_INS_AFTER: begin
        if (full) begin
          out_d.status = STAT_FULL;
        end else if (!found) begin
          out_d.status = STAT_NOT_FOUND;
        end else begin
          mode  = MODE_AFTER;
          cnt_d = cnt_q + 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (empty) begin
          out_d.status = STAT_EMPTY;
        end else if (!found) begin
          out_d.status = STAT_NOT_FOUND;
        end else begin
          mode  = MODE_REMOVE;
          cnt_d = cnt_q - 1'b1;
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          out_d.status = STAT_EMPTY;
        end else begin
          mode            = MODE_POP;
          out_d.out_task  = FieldW'(task_w[0]);
          out_d.out_valid = 1'b1;
          cnt_d           = cnt_q - 1'b1;
        end
      end
      default: ;
    endcase
    out_d.occupancy = OccW'(cnt_d);
  end

  assign ctrl.capture = (state_q == ST_CMP);
  assign ctrl.by_id   = (act == ACT_INS_AFTER) || (act == ACT_REMOVE);
  assign ctrl.mode    = commit ? mode : MODE_NONE;

  // occupancy and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (commit) begin
      cnt_q       <= cnt_d;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // chain ends
  assign ge_w[0]       = 1'b0;
  assign seen_w[0]     = 1'b0;
  assign task_w[DEPTH] = '0;
  assign prio_w[DEPTH] = '0;

  // cell row
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [TW-1:0] left_task;
    logic [7:0]    left_prio;
    logic [TW-1:0] cell_task;
    logic [7:0]    cell_prio;

    if (k == 0) begin : g_head
      assign left_task = new_task;
      assign left_prio = req_q.priority_req;
    end else begin : g_body
      assign left_task = task_w[k-1];
      assign left_prio = prio_w[k-1];
    end

    tpq_cell #(
      .IDX   (k),
      .CNT_W (CntW),
      .TW    (TW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .cnt_i        (cnt_q),
      .new_task_i   (new_task),
      .new_prio_i   (req_q.priority_req),
      .key_i        (key),
      .left_task_i  (left_task),
      .left_prio_i  (left_prio),
      .left_ge_i    (ge_w[k]),
      .left_seen_i  (seen_w[k]),
      .right_task_i (task_w[k+1]),
      .right_prio_i (prio_w[k+1]),
      .task_o       (cell_task),
      .prio_o       (cell_prio),
      .ge_o         (ge_w[k+1]),
      .seen_o       (seen_w[k+1])
    );

    assign task_w[k] = cell_task;
    assign prio_w[k] = cell_prio;
  end

`ifndef ASSERT_OFF
  // occupancy stays within the row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("occupancy above depth");

  // a committed insert grows the queue by one entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && (mode == MODE_BACK || mode == MODE_FRONT ||
               mode == MODE_PRIO || mode == MODE_AFTER)
    |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("insert did not grow the queue");

  // a popped task is always reported with ok status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_valid |-> out_data_o.status == STAT_OK)
    else $error("popped task with error status");

  // occupancy reported matches the stored count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_data_o.occupancy == OccW'(cnt_q))
    else $error("reported occupancy mismatch");

  // an accepted item goes to the compare pass next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_CMP)
    else $error("accepted item not processed");
`endif

endmodule

`default_nettype wire

[tb/task_priority_queue_unit_test.sv]
// ----------------------------------------------------------------------------
// task_priority_queue_unit_test
// Self-checking bench for the task priority queue. A behavioral copy of the
// queue predicts status, popped task and occupancy for every accepted item;
// a monitor compares each result in order. Directed cases cover the empty
// queue, every operation and the full queue, then about a thousand random
// items run in fill-heavy and drain-heavy phases, mostly under random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module task_priority_queue_unit_test;
  import tpq_pkg::*;

  localparam int unsigned Depth      = DepthDef;
  localparam int unsigned TaskIdBits = TaskIdBitsDef;
  localparam logic [FieldW-1:0] IdMask = FieldW'((1 << TaskIdBits) - 1);

  // action codes the block ignores
  localparam logic [ActionW-1:0] ActReserved6 = 3'd6;
  localparam logic [ActionW-1:0] ActReserved7 = 3'd7;

  localparam int unsigned IdlePct      = 34;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned HoldCycles   = 100;
  localparam int unsigned MaxReports   = 40;
  localparam int unsigned RandomPhases = 10;
  localparam int unsigned PhaseItems   = 100;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  tpq_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  tpq_out_t out_data_o;

  // predicted queue contents, front at index 0
  logic [FieldW-1:0] q_task [Depth];
  logic [FieldW-1:0] q_prio [Depth];
  int                q_count;

  tpq_out_t    expected_results [$];
  int unsigned error_count;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned full_seen;
  int unsigned empty_seen;
  int unsigned not_found_seen;
  int unsigned pops_seen;
  int unsigned cycle_count;
  int unsigned hold_cycles;
  logic        steady_flow;

  task_priority_queue_unit #(
    .DEPTH       (Depth),
    .TASK_ID_BITS(TaskIdBits)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             expected_results.size());
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // queue predictor
  // ---------------------------------------------------------------------------

  // open a gap at pos and fill it
  function automatic void place_entry(input int pos, input logic [FieldW-1:0] id,
                                      input logic [FieldW-1:0] prio);
    for (int i = q_count; i > pos; i--) begin
      q_task[i] = q_task[i-1];
      q_prio[i] = q_prio[i-1];
    end
    q_task[pos] = id;
    q_prio[pos] = prio;
    q_count++;
  endfunction

  function automatic void drop_entry(input int pos);
    for (int i = pos; i + 1 < q_count; i++) begin
      q_task[i] = q_task[i+1];
      q_prio[i] = q_prio[i+1];
    end
    q_count--;
  endfunction

  // frontmost index holding id, q_count when absent
  function automatic int find_entry(input logic [FieldW-1:0] id);
    int pos;
    pos = q_count;
    for (int i = q_count - 1; i >= 0; i--) begin
      if (q_task[i] == id) pos = i;
    end
    return pos;
  endfunction

  function automatic tpq_out_t predict_queue_op(input tpq_in_t req);
    tpq_out_t          res;
    logic [FieldW-1:0] id;
    logic [FieldW-1:0] ref_id;
    logic              is_insert;
    int                pos;
    res        = '0;
    res.status = STAT_OK;
    id         = req.task_id & IdMask;
    ref_id     = req.ref_task & IdMask;
    is_insert  = (req.action == ACT_PUSH_BACK) || (req.action == ACT_PUSH_FRONT) ||
                 (req.action == ACT_INS_PRIO) || (req.action == ACT_INS_AFTER);
    if (is_insert && q_count >= Depth) begin
      res.status = STAT_FULL;
    end else begin
      case (req.action)
        ACT_PUSH_BACK: place_entry(q_count, id, req.priority_req);
        ACT_PUSH_FRONT: place_entry(0, id, req.priority_req);
        ACT_INS_PRIO: begin
          // front when at most the head, else ahead of the first greater one
          pos = 0;
          if (q_count != 0 && req.priority_req > q_prio[0]) begin
            pos = q_count;
            for (int i = q_count - 1; i >= 1; i--) begin
              if (q_prio[i] > req.priority_req) pos = i;
            end
          end
          place_entry(pos, id, req.priority_req);
        end
        ACT_INS_AFTER: begin
          pos = find_entry(ref_id);
          if (pos >= q_count) res.status = STAT_NOT_FOUND;
          else place_entry(pos + 1, id, req.priority_req);
        end
        ACT_REMOVE: begin
          if (q_count == 0) begin
            res.status = STAT_EMPTY;
          end else begin
            pos = find_entry(id);
            if (pos >= q_count) res.status = STAT_NOT_FOUND;
            else drop_entry(pos);
          end
        end
        ACT_POP_FRONT: begin
          if (q_count == 0) begin
            res.status = STAT_EMPTY;
          end else begin
            res.out_task  = q_task[0];
            res.out_valid = 1'b1;
            drop_entry(0);
          end
        end
        default: ;
      endcase
    end
    res.occupancy = OccW'(q_count);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic tpq_in_t make_req(input logic [ActionW-1:0] action,
                                       input logic [FieldW-1:0] id,
                                       input logic [FieldW-1:0] prio,
                                       input logic [FieldW-1:0] ref_id);
    tpq_in_t req;
    req.action       = action;
    req.task_id      = id;
    req.priority_req = prio;
    req.ref_task     = ref_id;
    return req;
  endfunction

  // random item; small id and priority pools make matches and ties common
  function automatic tpq_in_t random_request(input int unsigned insert_pct);
    tpq_in_t     req;
    int unsigned roll;
    req.task_id      = $urandom_range(1) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
    req.priority_req = ($urandom_range(99) < 40) ? 8'($urandom_range(7)) :
                                                   8'($urandom_range(255));
    req.ref_task     = (q_count != 0 && $urandom_range(99) < 75) ?
                       q_task[$urandom_range(q_count - 1)] : 8'($urandom_range(255));
    roll = $urandom_range(99);
    if (roll < 3) begin
      req.action = roll[0] ? ActReserved6 : ActReserved7;
    end else if (roll < 3 + insert_pct) begin
      case ($urandom_range(3))
        0: req.action = ACT_PUSH_BACK;
        1: req.action = ACT_PUSH_FRONT;
        2: req.action = ACT_INS_PRIO;
        default: req.action = ACT_INS_AFTER;
      endcase
    end else if ($urandom_range(1)) begin
      req.action = ACT_REMOVE;
      if (q_count != 0 && $urandom_range(99) < 70) begin
        req.task_id = q_task[$urandom_range(q_count - 1)];
      end
    end else begin
      req.action = ACT_POP_FRONT;
    end
    return req;
  endfunction

  // offer one item and record its prediction when accepted
  task automatic send_request(input tpq_in_t req);
    @(negedge clk_i);
    if (!steady_flow) begin
      while ($urandom_range(99) < IdlePct) begin
        in_valid_i = 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i = 1'b1;
    in_data_i  = req;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(predict_queue_op(req));
    items_sent++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_empty_queue();
    send_request(make_req(ACT_POP_FRONT, 8'h12, 8'h34, 8'h56));
    send_request(make_req(ACT_REMOVE, 8'h00, 8'h00, 8'h00));
    send_request(make_req(ACT_INS_AFTER, 8'h01, 8'h02, 8'hFF));
    send_request(make_req(ActReserved6, 8'hFF, 8'hFF, 8'hFF));
    wait_drained();
  endtask

  task automatic test_each_operation();
    send_request(make_req(ACT_PUSH_BACK, 8'h00, 8'hFF, 8'h00));
    send_request(make_req(ACT_PUSH_FRONT, 8'hFF, 8'h00, 8'hFF));
    // equal to head priority goes to the front
    send_request(make_req(ACT_INS_PRIO, 8'h11, 8'h00, 8'h00));
    // no greater priority behind the head, so it goes to the tail
    send_request(make_req(ACT_INS_PRIO, 8'h22, 8'hFF, 8'h00));
    send_request(make_req(ACT_INS_PRIO, 8'h33, 8'h80, 8'h00));
    // reference at the tail, then at the head
    send_request(make_req(ACT_INS_AFTER, 8'h44, 8'h05, 8'h22));
    send_request(make_req(ACT_INS_AFTER, 8'h55, 8'h06, 8'h11));
    // duplicate id, removal takes the frontmost
    send_request(make_req(ACT_PUSH_BACK, 8'h33, 8'h01, 8'h00));
    send_request(make_req(ACT_REMOVE, 8'h33, 8'h00, 8'h00));
    send_request(make_req(ACT_REMOVE, 8'h99, 8'h00, 8'h00));
    send_request(make_req(ACT_INS_AFTER, 8'h66, 8'h07, 8'h99));
    // removing the head
    send_request(make_req(ACT_REMOVE, 8'h11, 8'h00, 8'h00));
    send_request(make_req(ActReserved7, 8'h00, 8'h00, 8'h00));
    // pop down to the last entry and past it
    while (q_count != 0) send_request(make_req(ACT_POP_FRONT, 8'h00, 8'h00, 8'h00));
    send_request(make_req(ACT_POP_FRONT, 8'hA5, 8'h5A, 8'hC3));
    wait_drained();
  endtask

  task automatic test_full_queue();
    while (q_count < Depth) send_request(random_request(97));
    send_request(make_req(ACT_PUSH_BACK, 8'h01, 8'h01, 8'h00));
    send_request(make_req(ACT_PUSH_FRONT, 8'h02, 8'h02, 8'h00));
    send_request(make_req(ACT_INS_PRIO, 8'h03, 8'h00, 8'h00));
    send_request(make_req(ACT_INS_AFTER, 8'h04, 8'h04, q_task[Depth-1]));
    send_request(make_req(ACT_REMOVE, q_task[Depth-1], 8'h00, 8'h00));
    send_request(make_req(ACT_INS_PRIO, 8'h05, 8'hFF, 8'h00));
    send_request(make_req(ACT_POP_FRONT, 8'h00, 8'h00, 8'h00));
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_output_holdoff();
    hold_cycles = HoldCycles;
    repeat (12) send_request(random_request(60));
    wait_drained();
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < RandomPhases; p++) begin
      steady_flow = (p == 4);
      repeat (PhaseItems) send_request(random_request((p % 2 == 0) ? 75 : 30));
      if (p % 3 == 2) wait_drained();
    end
    steady_flow = 1'b0;
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls, steady stretch and long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!rst_ni) begin
        out_ready_i = 1'b0;
      end else if (hold_cycles != 0) begin
        out_ready_i = 1'b0;
        hold_cycles--;
      end else if (steady_flow) begin
        out_ready_i = 1'b1;
      end else begin
        out_ready_i = ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor
  // ---------------------------------------------------------------------------
  initial begin
    tpq_out_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result %h", $time, out_data_o);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (want.status == STAT_FULL) full_seen++;
          if (want.status == STAT_EMPTY) empty_seen++;
          if (want.status == STAT_NOT_FOUND) not_found_seen++;
          if (want.out_valid) pops_seen++;
          if (out_data_o.out_task !== want.out_task) begin
            error_count++;
            if (error_count <= MaxReports)
              $display("%0t: out_task expected %h got %h", $time, want.out_task,
                       out_data_o.out_task);
          end
          if (out_data_o.out_valid !== want.out_valid) begin
            error_count++;
            if (error_count <= MaxReports)
              $display("%0t: out_valid expected %b got %b", $time, want.out_valid,
                       out_data_o.out_valid);
          end
          if (out_data_o.status !== want.status) begin
            error_count++;
            if (error_count <= MaxReports)
              $display("%0t: status expected %0d got %0d", $time, want.status,
                       out_data_o.status);
          end
          if (out_data_o.occupancy !== want.occupancy) begin
            error_count++;
            if (error_count <= MaxReports)
              $display("%0t: occupancy expected %0d got %0d", $time, want.occupancy,
                       out_data_o.occupancy);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence of tests
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_data_i       = '0;
    q_count         = 0;
    error_count     = 0;
    items_sent      = 0;
    results_checked = 0;
    full_seen       = 0;
    empty_seen      = 0;
    not_found_seen  = 0;
    pops_seen       = 0;
    hold_cycles     = 0;
    steady_flow     = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_queue();
    test_each_operation();
    test_full_queue();
    test_output_holdoff();
    test_random_traffic();

    // let any stray result show up
    repeat (8) @(posedge clk_i);
    $display("run covered %0d items, %0d results checked, %0d tasks popped", items_sent,
             results_checked, pops_seen);
    $display("queue full %0d times, empty %0d times, lookups missed %0d times", full_seen,
             empty_seen, not_found_seen);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[files.f]
src/tpq_pkg.sv
src/tpq_cell.sv
src/task_priority_queue_unit.sv
tb/task_priority_queue_unit_test.sv
